// File: hdl/cpf_pkg.sv
package cpf_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int CHARGE_WIDTH = 16;

   localparam int MAG_W   = COORD_WIDTH + 1;        // |second - first|
   localparam int LEN_W   = $clog2(MAG_W + 1);      // bit length of the largest magnitude
   localparam int NORM_W  = 20;                     // normalised magnitude bits
   localparam int S_W     = LEN_W + 1;              // signed normalising shift
   localparam int R2_W    = 2 * NORM_W + 2;         // sum of three squares
   localparam int ROOT_W  = NORM_W + 1;             // floor sqrt of r2
   localparam int DEN_W   = R2_W + ROOT_W;          // r2 * root
   localparam int QUOT_W  = 72;                     // quotient bits per division
   localparam int T_W     = 35;                     // bits of the quotient that can be set
   localparam int SCALE_W = 32;
   localparam int AQ_W    = CHARGE_WIDTH;           // magnitude of one charge
   localparam int CP_W    = 2 * CHARGE_WIDTH - 1;   // product of charge magnitudes
   localparam int TS_W    = T_W + SCALE_W;          // quotient times gain
   localparam int CH_W    = (TS_W + 2) / 3;         // one of three partial product chunks
   localparam int P_W     = 3 * CH_W + CP_W;        // full product
   localparam int K_W     = 7;                      // final shift amount
   localparam int OUT_W   = 48;
   localparam int MAG_OUT = OUT_W - 1;

   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int LANE_DEPTH = 5;

   localparam logic [R2_W-1:0] SQRT_FIRST_BIT = R2_W'(1) << (2 * (SQRT_STEPS - 1));
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

   typedef struct packed {
      logic [2:0][NORM_W-1:0] e;
      logic [2:0]             sg;
      logic signed [S_W-1:0]  s;
      logic                   coinc;
      logic [CP_W-1:0]        cp;
   } side_type;

   typedef struct packed {
      logic            vld;
      logic [R2_W-1:0] x;
      logic [R2_W-1:0] res;
      logic [R2_W-1:0] stp;
      logic [R2_W-1:0] r2;
      side_type        side;
   } sqrt_type;

   typedef struct packed {
      logic                   vld;
      logic [2:0][DEN_W-1:0]  rem;
      logic [2:0][T_W-1:0]    q;
      logic [DEN_W-1:0]       den;
      side_type               side;
   } div_type;

endpackage

// File: hdl/coulomb_pair_force.sv
// Pairwise Coulomb force, fully pipelined: one item accepted per cycle while the skid is empty.
// The pipe has 104 register stages (3 front stages, 21 root cells, 2 product stages,
// 72 divider cells, 5 gain/charge stages, output register).
// One item per cycle is accepted; input stalls only while the one-item skid is full.
// Reset (synchronous, active high) empties the pipe and sets force_scale to 1.0.
module coulomb_pair_force
   import cpf_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [SCALE_W-1:0]             csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_WIDTH-1:0]  req_first_x,
   input  logic signed [COORD_WIDTH-1:0]  req_first_y,
   input  logic signed [COORD_WIDTH-1:0]  req_first_z,
   input  logic signed [COORD_WIDTH-1:0]  req_second_x,
   input  logic signed [COORD_WIDTH-1:0]  req_second_y,
   input  logic signed [COORD_WIDTH-1:0]  req_second_z,
   input  logic signed [CHARGE_WIDTH-1:0] req_first_charge,
   input  logic signed [CHARGE_WIDTH-1:0] req_second_charge,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [OUT_W-1:0]        rsp_force_x,
   output logic signed [OUT_W-1:0]        rsp_force_y,
   output logic signed [OUT_W-1:0]        rsp_force_z,
   output logic                           rsp_coincident,
   output logic                           rsp_saturated
);

   // whole chain advances together unless the skid holds an item
   logic en;
   logic skid_full_ff;
   assign en = !skid_full_ff;

   logic [SCALE_W-1:0] scale_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // ---- stage 1: differences as sign/magnitude, charge product ----
   logic signed [MAG_W-1:0] d_in [3];
   logic signed [COORD_WIDTH-1:0] fa [3], fb [3];
   logic [MAG_W-1:0]  mag_in [3];
   logic signed [CHARGE_WIDTH:0] qa, qb;
   logic [AQ_W-1:0]   aqa, aqb;

   logic              v1_ff;
   logic [MAG_W-1:0]  mag1_ff [3];
   logic [2:0]        sg1_ff;
   logic [CP_W-1:0]   cp1_ff;

   always_comb begin
      fa[0] = req_first_x;  fa[1] = req_first_y;  fa[2] = req_first_z;
      fb[0] = req_second_x; fb[1] = req_second_y; fb[2] = req_second_z;
      for (int i = 0; i < 3; i++) begin
         d_in[i]   = MAG_W'(fb[i]) - MAG_W'(fa[i]);
         mag_in[i] = d_in[i][MAG_W-1] ? MAG_W'(-d_in[i]) : MAG_W'(d_in[i]);
      end
      qa  = (CHARGE_WIDTH+1)'(req_first_charge);
      qb  = (CHARGE_WIDTH+1)'(req_second_charge);
      aqa = AQ_W'(qa[CHARGE_WIDTH] ? -qa : qa);
      aqb = AQ_W'(qb[CHARGE_WIDTH] ? -qb : qb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag_in[i];
            sg1_ff[i]  <= d_in[i][MAG_W-1] ^ req_first_charge[CHARGE_WIDTH-1]
                          ^ req_second_charge[CHARGE_WIDTH-1];
         end
         cp1_ff <= CP_W'(aqa * aqb);
      end
   end

   // ---- stage 2: normalise so the largest magnitude has NORM_W bits ----
   logic [MAG_W-1:0] m_max;
   logic [LEN_W-1:0] len;
   logic signed [S_W-1:0] s_in;
   logic [MAG_W-1:0] e_full [3];

   logic     v2_ff;
   side_type side2_ff;

   always_comb begin
      m_max = mag1_ff[0];
      if (mag1_ff[1] > m_max) m_max = mag1_ff[1];
      if (mag1_ff[2] > m_max) m_max = mag1_ff[2];
      len = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (m_max[b]) len = LEN_W'(b + 1);
      end
      s_in = $signed({1'b0, len}) - S_W'(NORM_W);
      for (int i = 0; i < 3; i++) begin
         e_full[i] = s_in[S_W-1] ? (mag1_ff[i] << (-s_in)) : (mag1_ff[i] >> s_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            side2_ff.e[i] <= e_full[i][NORM_W-1:0];
         end
         side2_ff.sg    <= sg1_ff;
         side2_ff.s     <= s_in;
         side2_ff.coinc <= (m_max == '0);
         side2_ff.cp    <= cp1_ff;
      end
   end

   // ---- stage 3: squared length ----
   sqrt_type sq [SQRT_STEPS+1];
   logic [R2_W-1:0] r2_in;

   assign r2_in = R2_W'(side2_ff.e[0] * side2_ff.e[0]) + R2_W'(side2_ff.e[1] * side2_ff.e[1])
                + R2_W'(side2_ff.e[2] * side2_ff.e[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq[0].vld <= 1'b0;
      end else if (en) begin
         sq[0].vld <= v2_ff;
      end
      if (en) begin
         sq[0].x    <= r2_in;
         sq[0].res  <= '0;
         sq[0].stp  <= SQRT_FIRST_BIT;
         sq[0].r2   <= r2_in;
         sq[0].side <= side2_ff;
      end
   end

   // ---- integer square root: one cell per result bit ----
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      cpf_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (sq[j]),
         .d_out (sq[j+1])
      );
   end

   // ---- denominator r2 * root, split in two partial products ----
   localparam int RH_W = R2_W - R2_W / 2;
   localparam int RL_W = R2_W / 2;

   logic [ROOT_W-1:0] root;
   assign root = sq[SQRT_STEPS].res[ROOT_W-1:0];

   logic                   va_ff;
   logic [RH_W+ROOT_W-1:0] ph_ff;
   logic [RL_W+ROOT_W-1:0] pl_ff;
   side_type               sidea_ff;
   div_type                dv [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= 1'b0;
         dv[0].vld <= 1'b0;
      end else if (en) begin
         va_ff     <= sq[SQRT_STEPS].vld;
         dv[0].vld <= va_ff;
      end
      if (en) begin
         ph_ff    <= sq[SQRT_STEPS].r2[R2_W-1:RL_W] * root;
         pl_ff    <= sq[SQRT_STEPS].r2[RL_W-1:0] * root;
         sidea_ff <= sq[SQRT_STEPS].side;
         dv[0].den  <= DEN_W'({ph_ff, {RL_W{1'b0}}}) + DEN_W'(pl_ff);
         dv[0].side <= sidea_ff;
         for (int i = 0; i < 3; i++) begin
            dv[0].rem[i] <= DEN_W'(sidea_ff.e[i]);
            dv[0].q[i]   <= '0;
         end
      end
   end

   // ---- restoring division e * 2^72 / den: one cell per quotient bit ----
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      cpf_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (dv[j]),
         .d_out (dv[j+1])
      );
   end

   // ---- gain, charges, rounding and clipping per component ----
   side_type tail_side;
   logic [K_W-1:0] k_tail;
   logic signed [S_W+1:0] k_wide;
   logic [OUT_W-1:0] lane_force [3];
   logic [2:0] lane_clip;
   logic [LANE_DEPTH-1:0] lv_ff;
   logic [LANE_DEPTH-1:0] lc_ff;

   assign tail_side = dv[DIV_STEPS].side;
   assign k_wide    = (S_W+2)'(QUOT_W - SCALE_W) + ((S_W+2)'(tail_side.s) <<< 1);
   assign k_tail    = tail_side.coinc ? '0 : K_W'(k_wide);

   for (genvar i = 0; i < 3; i++) begin : g_lane
      cpf_scale_lane u_lane (
         .clock     (clock),
         .en        (en),
         .t         (dv[DIV_STEPS].q[i]),
         .scale     (scale_ff),
         .cp        (tail_side.cp),
         .k         (k_tail),
         .sg        (tail_side.sg[i]),
         .coinc     (tail_side.coinc),
         .force_out (lane_force[i]),
         .clip      (lane_clip[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= '0;
      end else if (en) begin
         lv_ff <= {lv_ff[LANE_DEPTH-2:0], dv[DIV_STEPS].vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lc_ff <= {lc_ff[LANE_DEPTH-2:0], tail_side.coinc};
      end
   end

   // ---- output register with a one-item skid ----
   logic tail_vld, out_take;
   logic [OUT_W-1:0] fx_ff, fy_ff, fz_ff, sfx_ff, sfy_ff, sfz_ff;
   logic coinc_ff, sat_ff, scoinc_ff, ssat_ff, rsp_valid_ff;

   assign tail_vld = lv_ff[LANE_DEPTH-1];
   assign out_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (out_take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (tail_vld) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_full_ff <= 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (out_take) begin
            fx_ff    <= sfx_ff;
            fy_ff    <= sfy_ff;
            fz_ff    <= sfz_ff;
            coinc_ff <= scoinc_ff;
            sat_ff   <= ssat_ff;
         end
      end else if (tail_vld) begin
         if (!rsp_valid_ff || out_take) begin
            fx_ff    <= lane_force[0];
            fy_ff    <= lane_force[1];
            fz_ff    <= lane_force[2];
            coinc_ff <= lc_ff[LANE_DEPTH-1];
            sat_ff   <= |lane_clip;
         end else begin
            sfx_ff    <= lane_force[0];
            sfy_ff    <= lane_force[1];
            sfz_ff    <= lane_force[2];
            scoinc_ff <= lc_ff[LANE_DEPTH-1];
            ssat_ff   <= |lane_clip;
         end
      end
   end

   assign req_stall      = skid_full_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_force_x    = fx_ff;
   assign rsp_force_y    = fy_ff;
   assign rsp_force_z    = fz_ff;
   assign rsp_coincident = coinc_ff;
   assign rsp_saturated  = sat_ff;

endmodule

// File: hdl/cpf_sqrt_cell.sv
module cpf_sqrt_cell
   import cpf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  sqrt_type d_in,
   output sqrt_type d_out
);

   sqrt_type d_ff, d_in_nxt;
   logic [R2_W-1:0] trial;
   logic take;

   // one step of the bit-by-bit root
   always_comb begin
      trial    = d_in.res + d_in.stp;
      take     = d_in.x >= trial;
      d_in_nxt = d_in;
      d_in_nxt.stp = d_in.stp >> 2;
      if (take) begin
         d_in_nxt.x   = d_in.x - trial;
         d_in_nxt.res = (d_in.res >> 1) + d_in.stp;
      end else begin
         d_in_nxt.res = d_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.vld <= 1'b0;
      end else if (en) begin
         d_ff <= d_in_nxt;
      end
   end

   assign d_out = d_ff;

endmodule

// File: hdl/cpf_div_cell.sv
module cpf_div_cell
   import cpf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  div_type d_in,
   output div_type d_out
);

   div_type d_ff, d_in_nxt;
   logic [DEN_W:0] sh [3];
   logic [2:0]     ge;

   // one restoring step for each of the three components
   always_comb begin
      d_in_nxt = d_in;
      for (int i = 0; i < 3; i++) begin
         sh[i] = {d_in.rem[i], 1'b0};
         ge[i] = sh[i] >= {1'b0, d_in.den};
         d_in_nxt.rem[i] = ge[i] ? DEN_W'(sh[i] - {1'b0, d_in.den}) : DEN_W'(sh[i]);
         d_in_nxt.q[i]   = {d_in.q[i][T_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.vld <= 1'b0;
      end else if (en) begin
         d_ff <= d_in_nxt;
      end
   end

   assign d_out = d_ff;

endmodule

// File: hdl/cpf_scale_lane.sv
module cpf_scale_lane
   import cpf_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [T_W-1:0]     t,
   input  logic [SCALE_W-1:0] scale,
   input  logic [CP_W-1:0]    cp,
   input  logic [K_W-1:0]     k,
   input  logic               sg,
   input  logic               coinc,
   output logic [OUT_W-1:0]   force_out,
   output logic               clip
);

   localparam int TH_W = T_W - T_W / 2;
   localparam int TL_W = T_W / 2;

   logic [TH_W+SCALE_W-1:0] a_ff;
   logic [TL_W+SCALE_W-1:0] b_ff;
   logic [TS_W-1:0]         ts_ff;
   logic [2:0][CH_W+CP_W-1:0] pp_ff;
   logic [P_W-1:0]          p_ff;
   logic [OUT_W-1:0]        force_ff;
   logic                    clip_ff;

   logic [CP_W-1:0] cp1_ff, cp2_ff;
   logic [K_W-1:0]  k1_ff, k2_ff, k3_ff, k4_ff;
   logic [3:0]      sg_ff, coinc_ff;

   logic [3*CH_W-1:0] ts_pad;
   logic [P_W:0]      rnd, sum, shd;
   logic              clip_in;
   logic [MAG_OUT-1:0] v;
   logic [OUT_W-1:0]  force_in;

   assign ts_pad = (3*CH_W)'(ts_ff);

   always_comb begin
      rnd     = (k4_ff != '0) ? ((P_W+1)'(1) << (k4_ff - K_W'(1))) : '0;
      sum     = {1'b0, p_ff} + rnd;
      shd     = sum >> k4_ff;
      clip_in = |shd[P_W:MAG_OUT];
      v       = clip_in ? {MAG_OUT{1'b1}} : shd[MAG_OUT-1:0];
      if (coinc_ff[3]) begin
         force_in = '0;
      end else if (sg_ff[3]) begin
         force_in = OUT_W'(0) - {1'b0, v};
      end else begin
         force_in = {1'b0, v};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= t[T_W-1:TL_W] * scale;
         b_ff     <= t[TL_W-1:0] * scale;
         cp1_ff   <= cp;
         k1_ff    <= k;
         ts_ff    <= TS_W'({a_ff, {TL_W{1'b0}}} + (TH_W+SCALE_W+TL_W)'(b_ff));
         cp2_ff   <= cp1_ff;
         k2_ff    <= k1_ff;
         for (int i = 0; i < 3; i++) begin
            pp_ff[i] <= ts_pad[i*CH_W +: CH_W] * cp2_ff;
         end
         k3_ff    <= k2_ff;
         p_ff     <= P_W'(pp_ff[0]) + (P_W'(pp_ff[1]) << CH_W) + (P_W'(pp_ff[2]) << (2*CH_W));
         k4_ff    <= k3_ff;
         sg_ff    <= {sg_ff[2:0], sg};
         coinc_ff <= {coinc_ff[2:0], coinc};
         force_ff <= force_in;
         clip_ff  <= clip_in && !coinc_ff[3];
      end
   end

   assign force_out = force_ff;
   assign clip      = clip_ff;

endmodule
